// File: src/tasa_pkg.sv
package tasa_pkg;

  localparam int unsigned SIZE_W             = 4;
  localparam int unsigned SLICE_W            = 4;
  localparam int unsigned SLOT_W             = 22;
  localparam int unsigned COORD_W            = 11;
  localparam int unsigned HANDLE_W           = 20;
  localparam int unsigned HANDLE_SLICE_SHIFT = 16;
  localparam int unsigned HANDLE_SLOT_MASK   = 32'h0000_FFFF;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    RES_NORMAL,
    RES_FULL,
    RES_CLEARED
  } res_kind_t;

  typedef struct packed {
    logic      load;
    logic      clear;
    logic      scan_first;
    logic      scan_next;
    logic      take_hit;
    logic      take_new;
    logic      write_back;
    logic      res_load;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic too_big;
    logic none_open;
    logic hit;
    logic last;
    logic at_max;
    logic out_free;
  } sts_t;

endpackage

// File: src/tasa_in_if.sv
interface tasa_in_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [tasa_pkg::SIZE_W-1:0]    size_log2;

  modport source (output valid, output opcode, output size_log2, input ready);
  modport sink   (input valid, input opcode, input size_log2, output ready);
endinterface

// File: src/tasa_out_if.sv
interface tasa_out_if;
  logic                           valid;
  logic                           ready;
  logic [tasa_pkg::SLICE_W-1:0]   slice_index;
  logic [tasa_pkg::SLOT_W-1:0]    slot_number;
  logic [tasa_pkg::COORD_W-1:0]   x_origin;
  logic [tasa_pkg::COORD_W-1:0]   y_origin;
  logic [tasa_pkg::HANDLE_W-1:0]  handle;
  logic                           table_full;

  modport source (
    output valid, output slice_index, output slot_number, output x_origin,
    output y_origin, output handle, output table_full, input ready
  );
  modport sink (
    input valid, input slice_index, input slot_number, input x_origin,
    input y_origin, input handle, input table_full, output ready
  );
endinterface

// File: src/tasa_ctrl.sv
module tasa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tasa_pkg::sts_t   sts,
  output tasa_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_OPEN,
    S_UPDATE,
    S_RESULT
  } state_t;

  state_t              state_r, state_nxt;
  tasa_pkg::res_kind_t kind_r, kind_nxt;

  always_comb begin
    cmd          = '0;
    cmd.res_kind = kind_r;
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    in_ready     = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.scan_first = 1'b1;
        priority if (sts.is_clear) begin
          cmd.clear = 1'b1;
          kind_nxt  = tasa_pkg::RES_CLEARED;
          state_nxt = S_RESULT;
        end else if (sts.too_big) begin
          kind_nxt  = tasa_pkg::RES_FULL;
          state_nxt = S_RESULT;
        end else if (sts.none_open) begin
          kind_nxt  = tasa_pkg::RES_NORMAL;
          state_nxt = S_OPEN;
        end else begin
          kind_nxt  = tasa_pkg::RES_NORMAL;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (sts.hit) begin
          cmd.take_hit = 1'b1;
          state_nxt    = S_UPDATE;
        end else if (sts.last) begin
          if (sts.at_max) begin
            kind_nxt  = tasa_pkg::RES_FULL;
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_OPEN;
          end
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_OPEN: begin
        cmd.take_new = 1'b1;
        state_nxt    = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.write_back = 1'b1;
        state_nxt      = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= tasa_pkg::RES_NORMAL;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

// File: src/tasa_dp.sv
module tasa_dp #(
  parameter int unsigned SLICE_SIDE_LOG2 = 11,
  parameter int unsigned MAX_SLICES      = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tasa_pkg::cmd_t                   cmd,
  output tasa_pkg::sts_t                   sts,
  input  logic                             in_opcode,
  input  logic [tasa_pkg::SIZE_W-1:0]      in_size_log2,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tasa_pkg::SLICE_W-1:0]     out_slice_index,
  output logic [tasa_pkg::SLOT_W-1:0]      out_slot_number,
  output logic [tasa_pkg::COORD_W-1:0]     out_x_origin,
  output logic [tasa_pkg::COORD_W-1:0]     out_y_origin,
  output logic [tasa_pkg::HANDLE_W-1:0]    out_handle,
  output logic                             out_table_full
);

  localparam int unsigned IW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
  localparam int unsigned CW = $clog2(MAX_SLICES + 1);
  localparam int unsigned FW = 2 * SLICE_SIDE_LOG2 + 1;
  localparam int unsigned EW = tasa_pkg::SIZE_W + FW;

  logic                          op_r;
  logic [tasa_pkg::SIZE_W-1:0]   size_r;
  logic [CW-1:0]                 open_r;
  logic [IW-1:0]                 scan_idx_r;
  logic [IW-1:0]                 chosen_r;
  logic [IW-1:0]                 rd_addr;
  logic [FW-1:0]                 slot_r;
  logic [EW-1:0]                 mem [MAX_SLICES];
  logic [EW-1:0]                 rd_r;
  logic [tasa_pkg::SIZE_W-1:0]   rd_side;
  logic [FW-1:0]                 rd_fill;
  logic [4:0]                    pr;
  logic [FW-1:0]                 cap;
  logic [31:0]                   slot_ext;
  logic [31:0]                   slice_ext;
  logic [31:0]                   x32;
  logic [31:0]                   y32;
  logic [31:0]                   handle32;

  logic                          out_valid_r;
  logic [tasa_pkg::SLICE_W-1:0]  slice_r;
  logic [tasa_pkg::SLOT_W-1:0]   slot_out_r;
  logic [tasa_pkg::COORD_W-1:0]  x_r;
  logic [tasa_pkg::COORD_W-1:0]  y_r;
  logic [tasa_pkg::HANDLE_W-1:0] handle_r;
  logic                          full_r;

  assign rd_side = rd_r[EW-1:FW];
  assign rd_fill = rd_r[FW-1:0];
  assign pr      = 5'(SLICE_SIDE_LOG2) - {1'b0, size_r};
  assign cap     = FW'(1) << {pr, 1'b0};
  assign rd_addr = cmd.scan_first ? '0 : IW'(scan_idx_r + IW'(1));

  assign slot_ext  = 32'(slot_r);
  assign slice_ext = 32'(chosen_r);
  assign x32       = (slot_ext & ((32'd1 << pr) - 32'd1)) << size_r;
  assign y32       = (slot_ext >> pr) << size_r;
  assign handle32  = (slice_ext << tasa_pkg::HANDLE_SLICE_SHIFT)
                   | (slot_ext & tasa_pkg::HANDLE_SLOT_MASK);

  always_comb begin
    sts           = '0;
    sts.is_clear  = (op_r == tasa_pkg::OP_CLEAR);
    sts.too_big   = (5'(size_r) > 5'(SLICE_SIDE_LOG2));
    sts.none_open = (open_r == '0);
    sts.hit       = (rd_side == size_r) && (rd_fill < cap);
    sts.last      = ((CW'(scan_idx_r) + CW'(1)) == open_r);
    sts.at_max    = (open_r == CW'(MAX_SLICES));
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.write_back) begin
      mem[chosen_r] <= {size_r, slot_r + FW'(1)};
    end
    if (cmd.scan_first || cmd.scan_next) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      size_r <= in_size_log2;
    end
    if (cmd.scan_first || cmd.scan_next) begin
      scan_idx_r <= rd_addr;
    end
    if (cmd.take_hit) begin
      chosen_r <= scan_idx_r;
      slot_r   <= rd_fill;
    end else if (cmd.take_new) begin
      chosen_r <= IW'(open_r);
      slot_r   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else if (cmd.clear) begin
      open_r <= '0;
    end else if (cmd.take_new) begin
      open_r <= open_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.res_kind)
        tasa_pkg::RES_NORMAL: begin
          slice_r    <= tasa_pkg::SLICE_W'(slice_ext);
          slot_out_r <= tasa_pkg::SLOT_W'(slot_ext);
          x_r        <= tasa_pkg::COORD_W'(x32);
          y_r        <= tasa_pkg::COORD_W'(y32);
          handle_r   <= tasa_pkg::HANDLE_W'(handle32);
          full_r     <= 1'b0;
        end
        tasa_pkg::RES_FULL: begin
          slice_r    <= '0;
          slot_out_r <= '0;
          x_r        <= '0;
          y_r        <= '0;
          handle_r   <= '0;
          full_r     <= 1'b1;
        end
        default: begin
          slice_r    <= '0;
          slot_out_r <= '0;
          x_r        <= '0;
          y_r        <= '0;
          handle_r   <= '0;
          full_r     <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slice_index = slice_r;
  assign out_slot_number = slot_out_r;
  assign out_x_origin    = x_r;
  assign out_y_origin    = y_r;
  assign out_handle      = handle_r;
  assign out_table_full  = full_r;

endmodule

// File: src/texture_atlas_slot_allocator.sv
// Steps to the result register: a clear goes from decode to the result, and an oversized texture
// or a full table gives table_full; else the open slices are scanned, one entry per cycle, until
// one has room, or a new slice is opened if none has, and the chosen slice is written back.
// Requests: one at a time; the next is accepted the cycle after the result is registered.
// Reset: synchronous, active-low rst_n empties the table at once by zeroing the open count.
module texture_atlas_slot_allocator #(
  parameter int unsigned SLICE_SIDE_LOG2 = 11,
  parameter int unsigned MAX_SLICES      = 16
) (
  input logic        clk,
  input logic        rst_n,
  tasa_in_if.sink    in_ch,
  tasa_out_if.source out_ch
);

  tasa_pkg::cmd_t cmd;
  tasa_pkg::sts_t sts;

  tasa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tasa_dp #(
    .SLICE_SIDE_LOG2 (SLICE_SIDE_LOG2),
    .MAX_SLICES      (MAX_SLICES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_ch.opcode),
    .in_size_log2    (in_ch.size_log2),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_slice_index (out_ch.slice_index),
    .out_slot_number (out_ch.slot_number),
    .out_x_origin    (out_ch.x_origin),
    .out_y_origin    (out_ch.y_origin),
    .out_handle      (out_ch.handle),
    .out_table_full  (out_ch.table_full)
  );

endmodule
